### rtl/cartridge_bank_mapper_with_save_ram_unit_macros.svh
// ----------------------------------------------------------------------------
// Cartridge bank mapper assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_MAPPER_WITH_SAVE_RAM_UNIT_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_SAVE_RAM_UNIT_MACROS_SVH

// Both sides sampled at the same clock edge.
`define CBM_ASSERT_SAME(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("cartridge bank mapper check failed");

// The consequence is sampled at the following clock edge.
`define CBM_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("cartridge bank mapper check failed");

`endif

### rtl/cbm_pkg.sv
// ----------------------------------------------------------------------------
// Cartridge bank mapper package
// Shared codes, widths and the command and status groups of the mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package cbm_pkg;

	localparam int ADDR_W    = 24;
	localparam int DATA_W    = 16;
	localparam int ROM_W     = 25;
	localparam int BANK_W    = 6;
	localparam int OFFSET_W  = 19;
	localparam int REG_W     = 8;
	localparam int NUM_WIN   = 8;
	localparam int WIN_W     = 3;
	localparam int MASK_W    = 16;
	localparam int CFG_IDX_W = 2;

	typedef logic [1:0] op_t;
	localparam op_t OP_SAVE_RD  = 2'd0;
	localparam op_t OP_SAVE_WR  = 2'd1;
	localparam op_t OP_BANK_WR  = 2'd2;
	localparam op_t OP_XLATE    = 2'd3;

	typedef logic [1:0] lanes_t;
	localparam lanes_t LANES_BOTH = 2'd0;
	localparam lanes_t LANES_EVEN = 2'd1;
	localparam lanes_t LANES_ODD  = 2'd2;
	localparam lanes_t LANES_NONE = 2'd3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_SRAM_ONLY = 2'd0;
	localparam cfg_idx_t CFG_LANES     = 2'd1;
	localparam cfg_idx_t CFG_SAVE_MASK = 2'd2;
	localparam cfg_idx_t CFG_BANK_MASK = 2'd3;

	localparam logic [1:0] SAVE_UNLOCK = 2'b01;
	localparam logic [7:0] LANE_OPEN   = 8'hFF;

	typedef struct packed {
		logic              sram_only;
		lanes_t            lanes;
		logic [MASK_W-1:0] save_mask;
		logic [BANK_W-1:0] bank_mask;
	} cfg_t;

	typedef struct packed {
		logic load_item;
		logic mem_rd0;
		logic mem_rd1;
		logic mem_wr0;
		logic mem_wr1;
		logic cap_hi;
		logic bank_wr;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic two_access;
	} status_t;

endpackage

`default_nettype wire

### rtl/cbm_ctrl.sv
// ----------------------------------------------------------------------------
// Cartridge bank mapper sequencer
// Steps each accepted access through the save memory port and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_ctrl
	import cbm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	output logic         out_valid,
	input  wire logic    out_stall,
	input  wire status_t status,
	output cmd_t         cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_RD1  = 3'd2;
	localparam logic [2:0] S_WR1  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (status.op)
					OP_SAVE_RD: begin
						cmd.mem_rd0 = 1'b1;
						state_d     = S_RD1;
					end
					OP_SAVE_WR: begin
						cmd.mem_wr0 = 1'b1;
						state_d     = status.two_access ? S_WR1 : S_OUT;
					end
					OP_BANK_WR: begin
						cmd.bank_wr = 1'b1;
						state_d     = S_OUT;
					end
					OP_XLATE: begin
						state_d = S_OUT;
					end
				endcase
			end
			S_RD1: begin
				cmd.cap_hi  = 1'b1;
				cmd.mem_rd1 = status.two_access;
				state_d     = S_OUT;
			end
			S_WR1: begin
				cmd.mem_wr1 = 1'b1;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/cbm_datapath.sv
// ----------------------------------------------------------------------------
// Cartridge bank mapper datapath
// Holds the access, the bank registers, the save memory and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_datapath
	import cbm_pkg::*;
#(
	parameter int SAVE_ADDR_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire cmd_t              cmd,
	output status_t                status,
	input  wire op_t               opcode,
	input  wire logic [ADDR_W-1:0] address,
	input  wire logic              is_word,
	input  wire logic [DATA_W-1:0] write_data,
	output logic [DATA_W-1:0]      read_data,
	output logic [ROM_W-1:0]       rom_address,
	output logic                   rom_mapped
);

	localparam int SAVE_DEPTH = 1 << SAVE_ADDR_BITS;

	op_t                      op_q;
	logic [ADDR_W-1:0]        addr_q;
	logic                     word_q;
	logic [DATA_W-1:0]        data_q;
	logic [REG_W-1:0]         hi_q;
	logic [REG_W-1:0]         rdata_q;
	logic [REG_W-1:0]         bank_q [NUM_WIN];
	logic [REG_W-1:0]         mem [SAVE_DEPTH];

	logic [SAVE_ADDR_BITS-1:0] idx;
	logic [SAVE_ADDR_BITS-1:0] idx_half;
	logic [SAVE_ADDR_BITS-1:0] idx_next;
	logic [SAVE_ADDR_BITS-1:0] mem_addr;
	logic                      mem_we;
	logic [REG_W-1:0]          mem_wdata;
	logic                      lane_ok;
	logic                      unlocked;

	logic [DATA_W-1:0]   rd_res;
	logic [ROM_W-1:0]    rom_res;
	logic                mapped_res;
	logic [WIN_W-1:0]    win;
	logic [REG_W-1:0]    bank_sel;
	logic [BANK_W-1:0]   bank;

	assign idx      = addr_q[SAVE_ADDR_BITS-1:0] & cfg.save_mask[SAVE_ADDR_BITS-1:0];
	assign idx_half = {1'b0, idx[SAVE_ADDR_BITS-1:1]};
	assign idx_next = idx + {{(SAVE_ADDR_BITS-1){1'b0}}, 1'b1};
	assign unlocked = (bank_q[0][1:0] == SAVE_UNLOCK);

	assign status.op         = op_q;
	assign status.two_access = word_q && (cfg.lanes == LANES_BOTH);

	always_comb begin
		lane_ok = 1'b0;
		unique case (cfg.lanes)
			LANES_BOTH: lane_ok = 1'b1;
			LANES_EVEN: lane_ok = word_q || !idx[0];
			LANES_ODD:  lane_ok = word_q || idx[0];
			LANES_NONE: lane_ok = 1'b0;
		endcase
	end

	always_comb begin
		mem_addr = (cfg.lanes == LANES_BOTH) ? idx : idx_half;
		if (cmd.mem_rd1 || cmd.mem_wr1) begin
			mem_addr = idx_next;
		end
		mem_we = unlocked && ((cmd.mem_wr0 && lane_ok) || cmd.mem_wr1);
		if (cmd.mem_wr0 && word_q && (cfg.lanes != LANES_ODD)) begin
			mem_wdata = data_q[DATA_W-1:REG_W];
		end else begin
			mem_wdata = data_q[REG_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (cmd.mem_rd0 || cmd.mem_rd1) begin
			rdata_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q   <= opcode;
			addr_q <= address;
			word_q <= is_word;
			data_q <= write_data;
		end
		if (cmd.cap_hi) begin
			hi_q <= rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WIN; i++) begin
				bank_q[i] <= REG_W'(i);
			end
		end else if (cmd.bank_wr && (word_q || addr_q[0])) begin
			bank_q[addr_q[WIN_W:1]] <= data_q[REG_W-1:0];
		end
	end

	always_comb begin
		rd_res = {LANE_OPEN, LANE_OPEN};
		if (word_q) begin
			unique case (cfg.lanes)
				LANES_BOTH: rd_res = {hi_q, rdata_q};
				LANES_EVEN: rd_res = {rdata_q, LANE_OPEN};
				LANES_ODD:  rd_res = {LANE_OPEN, rdata_q};
				LANES_NONE: rd_res = {LANE_OPEN, LANE_OPEN};
			endcase
		end else begin
			unique case (cfg.lanes)
				LANES_BOTH: rd_res = {8'h00, rdata_q};
				LANES_EVEN: rd_res = {8'h00, idx[0] ? LANE_OPEN : rdata_q};
				LANES_ODD:  rd_res = {8'h00, idx[0] ? rdata_q : LANE_OPEN};
				LANES_NONE: rd_res = {8'h00, LANE_OPEN};
			endcase
		end
	end

	assign win      = addr_q[OFFSET_W+WIN_W-1:OFFSET_W];
	assign bank_sel = ((win == '0) || cfg.sram_only) ? {{(REG_W-WIN_W){1'b0}}, win}
		: bank_q[win];
	assign bank     = bank_sel[BANK_W-1:0] & cfg.bank_mask;

	always_comb begin
		if (win[WIN_W-1] && bank_q[0][0]) begin
			rom_res    = '0;
			mapped_res = 1'b0;
		end else begin
			rom_res    = {bank, addr_q[OFFSET_W-1:0]};
			mapped_res = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			read_data   <= (op_q == OP_SAVE_RD) ? rd_res : '0;
			rom_address <= (op_q == OP_XLATE) ? rom_res : '0;
			rom_mapped  <= (op_q == OP_XLATE) && mapped_res;
		end
	end

endmodule

`default_nettype wire

### rtl/cartridge_bank_mapper_with_save_ram_unit.sv
// Without output stalls, save reads and word writes with both lanes wired go from
// acceptance through the execute state, a second single-port save memory step and
// the output state; every other access skips the second step. One access is in flight
// at a time, so no new word is taken until its result is loaded into the output register.
// Reset clears the sequencer and sets the configuration and bank registers to defaults,
// bank register i to i; the save memory keeps its contents and needs no clearing pass.
// ----------------------------------------------------------------------------
// Cartridge bank mapper with save RAM
// Bank register file, ROM address translation and lane-wired save memory.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cartridge_bank_mapper_with_save_ram_unit_macros.svh"

module cartridge_bank_mapper_with_save_ram_unit
	import cbm_pkg::*;
#(
	parameter int SAVE_ADDR_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire cfg_idx_t          cfg_index,
	input  wire logic [DATA_W-1:0] cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire op_t               opcode,
	input  wire logic [ADDR_W-1:0] address,
	input  wire logic              is_word,
	input  wire logic [DATA_W-1:0] write_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [DATA_W-1:0]      read_data,
	output logic [ROM_W-1:0]       rom_address,
	output logic                   rom_mapped
);

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sram_only <= 1'b0;
			cfg_q.lanes     <= LANES_BOTH;
			cfg_q.save_mask <= '1;
			cfg_q.bank_mask <= BANK_W'(7);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SRAM_ONLY: cfg_q.sram_only <= cfg_data[0];
				CFG_LANES:     cfg_q.lanes     <= cfg_data[1:0];
				CFG_SAVE_MASK: cfg_q.save_mask <= cfg_data[MASK_W-1:0];
				CFG_BANK_MASK: cfg_q.bank_mask <= cfg_data[BANK_W-1:0];
			endcase
		end
	end

	cbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	cbm_datapath #(
		.SAVE_ADDR_BITS (SAVE_ADDR_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd         (cmd),
		.status      (status),
		.opcode      (opcode),
		.address     (address),
		.is_word     (is_word),
		.write_data  (write_data),
		.read_data   (read_data),
		.rom_address (rom_address),
		.rom_mapped  (rom_mapped)
	);

	`CBM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`CBM_ASSERT_SAME(a_result_from_busy, $rose(out_valid), $past(in_stall))
	`CBM_ASSERT_SAME(a_mapped_no_read, out_valid && rom_mapped, read_data == '0)
	`CBM_ASSERT_SAME(a_unmapped_zero, out_valid && !rom_mapped, rom_address == '0)

endmodule

`default_nettype wire
